@@ rtl/core/ikur_pkg.sv @@
// Shared types, constants and helpers for the IKur current and gating pipeline.
package ikur_pkg;

    // Fixed-point constants, Q30 unless noted
    localparam logic [30:0] Q30_ONE    = 31'd1073741824;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [29:0] TAUA_SCALE = 30'd9663676;
    localparam logic [31:0] TAUA_FLOOR = 32'd536871;
    localparam logic [29:0] TAUI_SCALE = 30'd633507676;
    localparam logic [31:0] TAUI_FLOOR = 32'd3274912563;

    // Exponential series length and reciprocal constants for division by j
    localparam int EXP_TERMS = 12;
    localparam logic [30:0] HORN_MUL [1:12] = '{
        31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
        31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
        31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766
    };
    localparam int HORN_SHIFT [1:12] = '{30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34};

    // Logistic flavors: activation steady state, inactivation steady state, two time constants
    typedef enum logic [1:0] {
        LK_AINF = 2'd0,
        LK_IINF = 2'd1,
        LK_TAUA = 2'd2,
        LK_TAUI = 2'd3
    } lkind_t;

    // Voltage offset (Q8.8), sign flip, and exact split of 10*log2(e)/(256*div)
    localparam logic signed [17:0] LK_OFS [4] = '{18'sd1536, 18'sd1920, 18'sd1280, 18'sd15360};
    localparam logic             LK_FLIP [4] = '{1'b1, 1'b0, 1'b0, 1'b0};
    localparam logic [19:0]      LK_WQ [4]   = '{20'd703616, 20'd605110, 20'd504258, 20'd605110};
    localparam logic [14:0]      LK_WR [4]   = '{15'd10194, 15'd4050, 15'd14290, 15'd4050};
    localparam logic [23:0]      LK_WM [4]   = '{24'd12485371, 24'd10737419, 24'd8947849,
                                                 24'd10737419};

    // Pipeline depths
    localparam int LOGI_FRONT = 5;
    localparam int LDIV_Q_W   = 31;
    localparam int LOGI_LAT   = LOGI_FRONT + 2 * EXP_TERMS + 1 + LDIV_Q_W;
    localparam int RDIV_Q_W   = 32;
    localparam int CUR_LAT    = 5;
    localparam int TOP_LAT    = LOGI_LAT + 2 + RDIV_Q_W + 1;

    // Sign and magnitude to saturated two's complement 32 bits
    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        if (neg) begin
            r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        end else begin
            r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ikur_current_and_gating_rates_top.sv @@
// Top level: IKur current and gate derivatives, one cell per request.
// Throughput: one request per cycle while the output is not stalled; the
// pipeline depth is dominated by the two bit-serial divider pipelines
// (31 stages for the logistic, 32 for the rates).
// A stalled output register holds the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears valid bits and conductance_gain.
module ikur_current_and_gating_rates_top
    import ikur_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,   // conductance_gain
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] membrane_voltage, [31:16] reversal_potential, [47:32] activation_gate,
    // [63:48] inactivation_gate, [79:64] conductance_scale, [111:80] capacitance
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] channel_current, [63:32] activation_rate, [95:64] inactivation_rate
    output logic [95:0]  m_tdata
);
    logic               en;
    logic               in_acc;
    logic [31:0]        gain_reg;
    logic [TOP_LAT-1:1] vld_reg;
    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;

    logic signed [15:0] membrane_voltage;
    logic signed [15:0] reversal_potential;
    logic [15:0]        activation_gate;
    logic [15:0]        inactivation_gate;
    logic [15:0]        conductance_scale;
    logic [31:0]        capacitance;

    assign membrane_voltage   = s_tdata[15:0];
    assign reversal_potential = s_tdata[31:16];
    assign activation_gate    = s_tdata[47:32];
    assign inactivation_gate  = s_tdata[63:48];
    assign conductance_scale  = s_tdata[79:64];
    assign capacitance        = s_tdata[111:80];

    // global advance: output register empty or being drained; no requests in reset
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;
    assign in_acc   = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // valid bits, one per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[TOP_LAT-2:1], in_acc};
            m_tvalid_reg <= vld_reg[TOP_LAT-1];
        end
    end

    // current path, then aligned with the rate path
    logic [31:0] cur_c;
    logic [31:0] cur_d;

    ikur_current u_current (
        .aclk (aclk),
        .en   (en),
        .gain (gain_reg),
        .vm   (membrane_voltage),
        .ek   (reversal_potential),
        .agate(activation_gate),
        .igate(inactivation_gate),
        .scale(conductance_scale),
        .cap  (capacitance),
        .cur  (cur_c)
    );

    ikur_delay #(.WIDTH(32), .DEPTH(TOP_LAT - 1 - CUR_LAT)) u_cur_dly (
        .aclk(aclk),
        .en  (en),
        .din (cur_c),
        .dout(cur_d)
    );

    // four logistic units on the membrane voltage
    logic [30:0] l_ainf, l_iinf, l_taua, l_taui;

    ikur_logistic #(.KIND(LK_AINF)) u_lg_ainf (
        .aclk(aclk), .en(en), .vm(membrane_voltage), .lval(l_ainf)
    );
    ikur_logistic #(.KIND(LK_IINF)) u_lg_iinf (
        .aclk(aclk), .en(en), .vm(membrane_voltage), .lval(l_iinf)
    );
    ikur_logistic #(.KIND(LK_TAUA)) u_lg_taua (
        .aclk(aclk), .en(en), .vm(membrane_voltage), .lval(l_taua)
    );
    ikur_logistic #(.KIND(LK_TAUI)) u_lg_taui (
        .aclk(aclk), .en(en), .vm(membrane_voltage), .lval(l_taui)
    );

    // gates travel alongside the logistics
    logic [31:0] gates_d;

    ikur_delay #(.WIDTH(32), .DEPTH(LOGI_LAT + 1)) u_gate_dly (
        .aclk(aclk),
        .en  (en),
        .din ({inactivation_gate, activation_gate}),
        .dout(gates_d)
    );

    // T1: time constant scaling multiply
    logic [60:0] tmul_a_reg, tmul_i_reg;
    logic [30:0] inf_a_reg, inf_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tmul_a_reg <= 61'(l_taua) * 61'(TAUA_SCALE);
            tmul_i_reg <= 61'(l_taui) * 61'(TAUI_SCALE);
            inf_a_reg  <= l_ainf;
            inf_i_reg  <= l_iinf;
        end
    end

    // T2: time constants and signed distance to steady state
    logic [30:0] g30_a, g30_i;
    logic        neg_a_c, neg_i_c;
    logic [31:0] tau_a_reg, tau_i_reg;
    logic [30:0] diff_a_reg, diff_i_reg;
    logic        neg_a_reg, neg_i_reg;

    assign g30_a   = {1'b0, gates_d[15:0], 14'd0};
    assign g30_i   = {1'b0, gates_d[31:16], 14'd0};
    assign neg_a_c = g30_a > inf_a_reg;
    assign neg_i_c = g30_i > inf_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tau_a_reg  <= 32'(tmul_a_reg[60:30]) + TAUA_FLOOR;
            tau_i_reg  <= 32'(tmul_i_reg[60:30]) + TAUI_FLOOR;
            diff_a_reg <= neg_a_c ? g30_a - inf_a_reg : inf_a_reg - g30_a;
            diff_i_reg <= neg_i_c ? g30_i - inf_i_reg : inf_i_reg - g30_i;
            neg_a_reg  <= neg_a_c;
            neg_i_reg  <= neg_i_c;
        end
    end

    // rate dividers: (diff << 20) / tau
    logic [31:0] q_a, q_i;
    logic [1:0]  neg_d;

    ikur_div #(.NUM_W(51), .DEN_W(32), .Q_W(RDIV_Q_W)) u_rdiv_a (
        .aclk(aclk),
        .en  (en),
        .num ({diff_a_reg, 20'd0}),
        .den (tau_a_reg),
        .quo (q_a)
    );

    ikur_div #(.NUM_W(51), .DEN_W(32), .Q_W(RDIV_Q_W)) u_rdiv_i (
        .aclk(aclk),
        .en  (en),
        .num ({diff_i_reg, 20'd0}),
        .den (tau_i_reg),
        .quo (q_i)
    );

    ikur_delay #(.WIDTH(2), .DEPTH(RDIV_Q_W)) u_sign_dly (
        .aclk(aclk),
        .en  (en),
        .din ({neg_i_reg, neg_a_reg}),
        .dout(neg_d)
    );

    // output register with saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sat32(neg_d[1], 64'(q_i)), sat32(neg_d[0], 64'(q_a)), cur_d};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a held output freezes the stage valid bits
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // an accepted request occupies the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> vld_reg[1])
        else $error("accepted request lost at entry");

    // logistic outputs never exceed one
    a_logistic_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LOGI_LAT] |-> (l_ainf <= Q30_ONE && l_iinf <= Q30_ONE
                               && l_taua <= Q30_ONE && l_taui <= Q30_ONE))
        else $error("logistic above one");

    // time constants never drop below their floors
    a_tau_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LOGI_LAT + 2] |-> (tau_a_reg >= TAUA_FLOOR && tau_i_reg >= TAUI_FLOOR))
        else $error("time constant below floor");
endmodule

@@ rtl/core/ikur_delay.sv @@
// Enabled shift-register delay line for side data.
module ikur_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] pipe_reg [DEPTH];

    // shift one place per advancing cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];
endmodule

@@ rtl/core/ikur_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module ikur_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 32,
    parameter int Q_W   = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);
    // remainder, low dividend bits turning into quotient bits, divisor
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   low_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        // upper dividend bits are below the divisor by construction
        if (i == 0) begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:Q_W]);
            assign low_in = num[Q_W-1:0];
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, low_in[Q_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                low_reg[i] <= {low_in[Q_W-2:0], ge};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = low_reg[Q_W-1];
endmodule

@@ rtl/core/ikur_logistic.sv @@
// Logistic 1/(1+e^z) of membrane voltage in Q1.30 through a fixed-length exponential.
module ikur_logistic
    import ikur_pkg::*;
#(
    parameter lkind_t KIND = LK_AINF
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] vm,
    output logic [30:0]        lval
);
    logic signed [17:0] s_c, a_c;
    logic [15:0]        s1_mag_reg;
    logic               s1_neg_reg;
    logic [35:0]        s2_pq_reg;
    logic [30:0]        s2_pr_reg;
    logic               s2_neg_reg;
    logic [46:0]        s3_t_reg;
    logic [35:0]        s3_pq_reg;
    logic               s3_neg_reg;
    logic [35:0]        w_c;
    logic [5:0]         s4_n_reg;
    logic [29:0]        s4_frac_reg;
    logic               s4_neg_reg;
    logic [59:0]        xprod_c;
    logic [29:0]        s5_x_reg;
    logic [5:0]         s5_n_reg;
    logic               s5_neg_reg;

    // stage 1: offset, flip, magnitude
    assign s_c = 18'(vm) + LK_OFS[KIND];
    assign a_c = LK_FLIP[KIND] ? -s_c : s_c;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg <= a_c[17] ? 16'(-a_c) : 16'(a_c);
            s1_neg_reg <= a_c[17];
        end
    end

    // stage 2: split multiply by 10*log2(e)/(256*div)
    always_ff @(posedge aclk) begin
        if (en) begin
            s2_pq_reg  <= 36'(s1_mag_reg) * 36'(LK_WQ[KIND]);
            s2_pr_reg  <= 31'(s1_mag_reg) * 31'(LK_WR[KIND]);
            s2_neg_reg <= s1_neg_reg;
        end
    end

    // stage 3: remainder part divided by div via reciprocal
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_t_reg   <= 47'(s2_pr_reg[30:8]) * 47'(LK_WM[KIND]);
            s3_pq_reg  <= s2_pq_reg;
            s3_neg_reg <= s2_neg_reg;
        end
    end

    // stage 4: w = |z|*log2(e) in Q30, split into integer and fraction
    assign w_c = s3_pq_reg + 36'(s3_t_reg[46:30]);

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_n_reg    <= w_c[35:30];
            s4_frac_reg <= w_c[29:0];
            s4_neg_reg  <= s3_neg_reg;
        end
    end

    // stage 5: fraction times ln2
    assign xprod_c = 60'(s4_frac_reg) * 60'(LN2_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_x_reg   <= xprod_c[59:30];
            s5_n_reg   <= s4_n_reg;
            s5_neg_reg <= s4_neg_reg;
        end
    end

    // Horner series for e^-x: two stages per term, j from 12 down to 1
    logic [29:0] cx_reg [2*EXP_TERMS];
    logic [5:0]  cn_reg [2*EXP_TERMS];
    logic        cg_reg [2*EXP_TERMS];
    logic [29:0] ya_reg [EXP_TERMS];
    logic [30:0] hb_reg [EXP_TERMS];

    for (genvar m = 0; m < 2 * EXP_TERMS; m++) begin : g_carry
        if (m == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (en) begin
                    cx_reg[m] <= s5_x_reg;
                    cn_reg[m] <= s5_n_reg;
                    cg_reg[m] <= s5_neg_reg;
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (en) begin
                    cx_reg[m] <= cx_reg[m-1];
                    cn_reg[m] <= cn_reg[m-1];
                    cg_reg[m] <= cg_reg[m-1];
                end
            end
        end
    end

    for (genvar k = 0; k < EXP_TERMS; k++) begin : g_term
        localparam int J = EXP_TERMS - k;
        logic [29:0] x_in;
        logic [30:0] h_in;
        logic [60:0] pa_c;
        logic [60:0] pb_c;
        logic [30:0] q_c;

        if (k == 0) begin : g_first
            assign x_in = s5_x_reg;
            assign h_in = Q30_ONE;
        end else begin : g_next
            assign x_in = cx_reg[2*k-1];
            assign h_in = hb_reg[k-1];
        end

        // x*h, then divide by j through reciprocal
        assign pa_c = 61'(x_in) * 61'(h_in);
        assign pb_c = 61'(ya_reg[k]) * 61'(HORN_MUL[J]);
        assign q_c  = 31'(pb_c >> HORN_SHIFT[J]);

        always_ff @(posedge aclk) begin
            if (en) begin
                ya_reg[k] <= pa_c[59:30];
                hb_reg[k] <= Q30_ONE - q_c;
            end
        end
    end

    // scale by 2^-n; underflow to zero for large n
    logic [30:0] u_reg;
    logic        u_neg_reg;
    logic [5:0]  n_last;

    assign n_last = cn_reg[2*EXP_TERMS-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg     <= (n_last >= 6'd31) ? 31'd0 : (hb_reg[EXP_TERMS-1] >> n_last);
            u_neg_reg <= cg_reg[2*EXP_TERMS-1];
        end
    end

    // logistic: u/(1+u) for z >= 0, 1/(1+u) otherwise
    logic [60:0] ldiv_num;
    logic [31:0] ldiv_den;

    assign ldiv_num = u_neg_reg ? (61'd1 << 60) : {u_reg, 30'd0};
    assign ldiv_den = 32'(Q30_ONE) + 32'(u_reg);

    ikur_div #(
        .NUM_W(61),
        .DEN_W(32),
        .Q_W  (LDIV_Q_W)
    ) u_ldiv (
        .aclk(aclk),
        .en  (en),
        .num (ldiv_num),
        .den (ldiv_den),
        .quo (lval)
    );
endmodule

@@ rtl/core/ikur_current.sv @@
// Channel current: product chain of conductance, gates, capacitance and driving force.
module ikur_current
    import ikur_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        gain,
    input  logic signed [15:0] vm,
    input  logic signed [15:0] ek,
    input  logic [15:0]        agate,
    input  logic [15:0]        igate,
    input  logic [15:0]        scale,
    input  logic [31:0]        cap,
    output logic [31:0]        cur
);
    logic signed [16:0] drive_c;
    logic [47:0]        gprod_c;
    logic [31:0]        ggprod_c;
    logic [31:0]        c1_g_reg;
    logic [15:0]        c1_gg_reg;
    logic [15:0]        c1_dmag_reg;
    logic               c1_dneg_reg;
    logic [31:0]        c1_cap_reg;
    logic [47:0]        pprod_c;
    logic [31:0]        c2_p_reg;
    logic [15:0]        c2_dmag_reg;
    logic               c2_dneg_reg;
    logic [31:0]        c2_cap_reg;
    logic [63:0]        aprod_c;
    logic [47:0]        c3_acc_reg;
    logic [15:0]        c3_dmag_reg;
    logic               c3_dneg_reg;
    logic [47:0]        c4_lo_reg;
    logic [31:0]        c4_hi_reg;
    logic               c4_dneg_reg;
    logic [63:0]        total_c;

    // stage 1: conductance, gate product, driving force
    assign drive_c  = 17'(vm) - 17'(ek);
    assign gprod_c  = 48'(scale) * 48'(gain);
    assign ggprod_c = 32'(agate) * 32'(igate);

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_g_reg    <= gprod_c[47:16];
            c1_gg_reg   <= ggprod_c[31:16];
            c1_dmag_reg <= drive_c[16] ? 16'(-drive_c) : 16'(drive_c);
            c1_dneg_reg <= drive_c[16];
            c1_cap_reg  <= cap;
        end
    end

    // stage 2: conductance times gates
    assign pprod_c = 48'(c1_g_reg) * 48'(c1_gg_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_p_reg    <= pprod_c[47:16];
            c2_dmag_reg <= c1_dmag_reg;
            c2_dneg_reg <= c1_dneg_reg;
            c2_cap_reg  <= c1_cap_reg;
        end
    end

    // stage 3: times capacitance
    assign aprod_c = 64'(c2_p_reg) * 64'(c2_cap_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_acc_reg  <= aprod_c[63:16];
            c3_dmag_reg <= c2_dmag_reg;
            c3_dneg_reg <= c2_dneg_reg;
        end
    end

    // stage 4: 48 x 16 product as two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            c4_lo_reg   <= 48'(c3_acc_reg[31:0]) * 48'(c3_dmag_reg);
            c4_hi_reg   <= 32'(c3_acc_reg[47:32]) * 32'(c3_dmag_reg);
            c4_dneg_reg <= c3_dneg_reg;
        end
    end

    // stage 5: combine, scale to Q16.16, saturate
    assign total_c = {c4_hi_reg, 32'd0} + 64'(c4_lo_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            cur <= sat32(c4_dneg_reg, {8'd0, total_c[63:8]});
        end
    end
endmodule
